FILE: hw/rtl/ffd_pkg.sv
// Shared types and constants for the flag-framed deframer.
package ffd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] crc_type;
   typedef logic [2:0]  status_type;

   localparam byte_type FLAG_BYTE    = 8'h7E;
   localparam byte_type ESC_BYTE     = 8'h7D;
   localparam byte_type ESC_FLAG     = 8'h5E;
   localparam byte_type ESC_ESC      = 8'h5D;
   localparam byte_type ESC_DEL      = 8'h5F;
   localparam byte_type DEL_BYTE     = 8'h7F;

   localparam crc_type  CRC_POLY     = 16'h1021;
   localparam crc_type  CRC_INIT     = 16'h0000;

   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_CRC     = 3'd1;
   localparam status_type ST_ESC     = 3'd2;
   localparam status_type ST_SHORT   = 3'd3;
   localparam status_type ST_OVER    = 3'd4;

endpackage

FILE: hw/rtl/flag_framed_unstuff_crc_deframer.sv
// Flag-framed byte deframer with escape removal and CRC-16 check.
//
// Raw link bytes enter on the req stream, one per beat. Bytes outside a frame
// are dropped until a 0x7E flag opens one; 0x7D escapes are undone, and the
// last two unstuffed bytes of a frame are held back as the FCS (low byte
// first) and never forwarded. Each forwarded payload byte comes out as a rsp
// beat with tlast low; the closing flag of a non-empty frame produces one beat
// with tlast high, tdata zero and the frame status in tuser (0 ok, 1 CRC
// mismatch, 2 bad escape, 3 too short, 4 overflow). The CRC is CRC-16-CCITT,
// init zero. It takes one byte per clock unless rsp_tready stalls it; each
// byte passes the input register, then the unstuff/CRC step into the result
// register; the one-byte CRC update is the longest path. The csr register
// sets the payload byte limit, clipped to MAX_FRAME_BYTES; it resets to 512.
module flag_framed_unstuff_crc_deframer #(
   parameter int MAX_FRAME_BYTES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data,   // max_payload_length
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // data_out
   output logic        rsp_tlast,     // frame_end
   output logic [2:0]  rsp_tuser      // frame_status
);
   import ffd_pkg::*;

   localparam int CW = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LW = (CW > 11) ? CW : 11;
   localparam logic [LW-1:0] MAX_LIMIT = LW'(MAX_FRAME_BYTES);

   logic [10:0]   limit_cfg_ff;
   logic          in_vld_ff;
   byte_type      in_byte_ff;

   logic          in_frame_ff, in_frame_in;
   logic          esc_ff, esc_in;
   byte_type      held0_ff, held0_in;
   byte_type      held1_ff, held1_in;
   logic [1:0]    held_count_ff, held_count_in;
   crc_type       crc_ff, crc_in;
   logic [CW-1:0] payload_count_ff, payload_count_in;
   status_type    error_ff, error_in;

   logic          rsp_vld_ff;
   byte_type      rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          emit;

   logic          advance;
   logic [LW-1:0] limit;
   crc_type       crc_next;

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign limit      = (LW'(limit_cfg_ff) > MAX_LIMIT) ? MAX_LIMIT : LW'(limit_cfg_ff);

   ffd_crc16 u_crc (
      .crc_i  (crc_ff),
      .data_i (held0_ff),
      .crc_o  (crc_next)
   );

   always_comb begin
      byte_type v;
      logic     take;
      in_frame_in      = in_frame_ff;
      esc_in           = esc_ff;
      held0_in         = held0_ff;
      held1_in         = held1_ff;
      held_count_in    = held_count_ff;
      crc_in           = crc_ff;
      payload_count_in = payload_count_ff;
      error_in         = error_ff;
      emit             = 1'b0;
      rsp_data_in      = 8'h00;
      rsp_last_in      = 1'b0;
      rsp_status_in    = ST_OK;
      v                = in_byte_ff;
      take             = 1'b0;

      if (!in_frame_ff) begin
         if (in_byte_ff == FLAG_BYTE) begin
            in_frame_in      = 1'b1;
            esc_in           = 1'b0;
            held0_in         = 8'h00;
            held1_in         = 8'h00;
            held_count_in    = 2'd0;
            crc_in           = CRC_INIT;
            payload_count_in = '0;
            error_in         = ST_OK;
         end
      end else if (in_byte_ff == FLAG_BYTE) begin
         if (held_count_ff != 2'd0 || esc_ff || error_ff != ST_OK ||
             payload_count_ff != '0) begin
            emit        = 1'b1;
            rsp_last_in = 1'b1;
            if (error_ff != ST_OK) begin
               rsp_status_in = error_ff;
            end else if (esc_ff) begin
               rsp_status_in = ST_ESC;
            end else if (held_count_ff < 2'd2) begin
               rsp_status_in = ST_SHORT;
            end else if (crc_ff == {held1_ff, held0_ff}) begin
               rsp_status_in = ST_OK;
            end else begin
               rsp_status_in = ST_CRC;
            end
            in_frame_in      = 1'b0;
            esc_in           = 1'b0;
            held0_in         = 8'h00;
            held1_in         = 8'h00;
            held_count_in    = 2'd0;
            crc_in           = CRC_INIT;
            payload_count_in = '0;
            error_in         = ST_OK;
         end
      end else if (error_ff == ST_OK) begin
         if (esc_ff) begin
            esc_in = 1'b0;
            take   = 1'b1;
            case (in_byte_ff)
               ESC_FLAG: v = FLAG_BYTE;
               ESC_ESC:  v = ESC_BYTE;
               ESC_DEL:  v = DEL_BYTE;
               default: begin
                  error_in = ST_ESC;
                  take     = 1'b0;
               end
            endcase
         end else if (in_byte_ff == ESC_BYTE) begin
            esc_in = 1'b1;
         end else begin
            take = 1'b1;
         end

         if (take) begin
            if (held_count_ff < 2'd2) begin
               if (held_count_ff == 2'd0) begin
                  held0_in = v;
               end else begin
                  held1_in = v;
               end
               held_count_in = held_count_ff + 2'd1;
            end else if (LW'(payload_count_ff) >= limit) begin
               error_in = ST_OVER;
            end else begin
               emit             = 1'b1;
               rsp_data_in      = held0_ff;
               crc_in           = crc_next;
               payload_count_in = payload_count_ff + CW'(1);
               held0_in         = held1_ff;
               held1_in         = v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_cfg_ff <= 11'd512;
      end else if (csr_wr_en) begin
         limit_cfg_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff      <= 1'b0;
         esc_ff           <= 1'b0;
         held0_ff         <= 8'h00;
         held1_ff         <= 8'h00;
         held_count_ff    <= 2'd0;
         crc_ff           <= CRC_INIT;
         payload_count_ff <= '0;
         error_ff         <= ST_OK;
      end else if (advance) begin
         in_frame_ff      <= in_frame_in;
         esc_ff           <= esc_in;
         held0_ff         <= held0_in;
         held1_ff         <= held1_in;
         held_count_ff    <= held_count_in;
         crc_ff           <= crc_in;
         payload_count_ff <= payload_count_in;
         error_ff         <= error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance && emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_end_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_last_ff |-> rsp_data_ff == 8'h00)
      else $error("end beat carries nonzero data");

   a_payload_status_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_last_ff |-> rsp_status_ff == ST_OK)
      else $error("payload beat carries a status");

   a_count_within_limit: assert property (@(posedge clock) disable iff (reset)
      LW'(payload_count_ff) <= MAX_LIMIT)
      else $error("payload count beyond frame size");

   a_held_before_payload: assert property (@(posedge clock) disable iff (reset)
      payload_count_ff != '0 |-> held_count_ff == 2'd2)
      else $error("payload forwarded without full FCS hold");

endmodule

FILE: hw/rtl/ffd_crc16.sv
// Byte-wide CRC-16-CCITT update, MSB first, no reflection.
module ffd_crc16 (
   input  ffd_pkg::crc_type  crc_i,
   input  ffd_pkg::byte_type data_i,
   output ffd_pkg::crc_type  crc_o
);
   import ffd_pkg::*;

   always_comb begin
      crc_type c;
      c = crc_i ^ {data_i, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      crc_o = c;
   end

endmodule
